### rtl/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

   localparam int MAX_STEPS       = 64;
   localparam int SLOTS_PER_TRACK = 8;
   localparam int TRACK_COUNT     = 4;
   localparam int SLOT_TOTAL      = TRACK_COUNT * SLOTS_PER_TRACK;
   localparam int SLOT_BITS       = $clog2(SLOT_TOTAL);

   localparam int DUR_W  = 10;
   localparam int NOTE_W = 7;
   localparam int SLOT_W = DUR_W + NOTE_W;
   localparam int PC_W   = 14;
   localparam int NT_W   = 15;
   localparam int STEP_W = 6;
   localparam int LOOP_W = 7;
   localparam int PPS_W  = 8;
   localparam int DIV_W  = 15;
   localparam int REM_W  = 14;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      CMD_PULSE  = 2'd0,
      CMD_TOGGLE = 2'd1,
      CMD_ADD    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_STATUS   = 3'd0,
      KIND_STEP     = 3'd1,
      KIND_NOTE_OFF = 3'd2,
      KIND_NOTE_OK  = 3'd3,
      KIND_FULL     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      REG_PPS   = 2'd0,
      REG_SWING = 2'd1,
      REG_LOOP  = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FINAL = 2'd2
   } state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] track_index;
      logic [6:0] note_number;
      logic [9:0] note_duration;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] step_number;
      logic [1:0] out_track;
      logic [6:0] out_note;
      logic       running;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [REM_W-1:0] divisor;
   } div_req_type;

endpackage

`default_nettype wire

### rtl/swing_step_sequencer_clock.sv
`default_nettype none

// Step sequencer clock with swing and 32 note-off timers (4 tracks of 8 slots).
// A clock pulse while running walks the note slots: they live in a
// single-port-write memory that is read, counted down and written back one
// slot per cycle, and the step check follows in the final state. Each note-off
// goes out as its own transfer; the slot walk holds while a note-off waits on a
// full result register. The counter and step wrap values come from a shared
// remainder unit that runs twice alongside the slot walk. Start/stop, add-note
// and pulses while stopped skip the slot walk. Registers sit at byte
// addresses 0 (pulses per step), 4 (swing offset) and 8 (loop length).

module swing_step_sequencer_clock (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ssc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ssc_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ssc_pkg::ADDR_W-1:0] paddr,
   input  logic [ssc_pkg::DATA_W-1:0] pwdata,
   output logic [ssc_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   import ssc_pkg::*;

   logic [PPS_W-1:0]  pps_ff;
   logic [PPS_W-1:0]  swing_ff;
   logic [LOOP_W-1:0] loop_ff;

   state_type              state_ff, state_in;
   req_type                cmd_ff, cmd_in;
   logic                   play_ff, play_in;
   logic [PC_W-1:0]        pc_ff, pc_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [NT_W-1:0]        nt_ff, nt_in;
   logic [SLOT_TOTAL-1:0]  busy_ff, busy_in;
   logic [SLOT_BITS:0]     rd_ptr_ff, rd_ptr_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [SLOT_BITS-1:0]   proc_idx_ff, proc_idx_in;
   logic                   phase_ff, phase_in;
   logic [STEP_W-1:0]      step_rem_ff, step_rem_in;
   logic [REM_W-1:0]       period_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                      rsp_load;
   rsp_type                   rsp_next;
   logic                      can_load;
   logic                      req_xfer;
   logic                      csr_wr;
   logic [PPS_W-1:0]          epps;
   logic [LOOP_W-1:0]         eloop;
   logic [LOOP_W+PPS_W-1:0]   period_full;
   div_req_type               div_req;
   logic                      div_done;
   logic [REM_W-1:0]          div_rem;

   logic                      ram_we;
   logic [SLOT_BITS-1:0]      ram_waddr;
   logic [SLOT_W-1:0]         ram_wdata;
   logic                      ram_re;
   logic [SLOT_W-1:0]         ram_rdata;
   logic [DUR_W-1:0]          rd_rem;
   logic [NOTE_W-1:0]         rd_note;
   logic                      slot_hit;
   logic                      slot_stall;

   logic                      fire;
   logic [LOOP_W-1:0]         next_inc;
   logic [LOOP_W-1:0]         next_idx;
   logic [STEP_W+PPS_W-1:0]   trig_prod;
   logic [NT_W-1:0]           trig_new;

   logic                      track_ok;
   logic [SLOTS_PER_TRACK-1:0] track_busy;
   logic                      free_found;
   logic [SLOT_BITS-1:0]      free_addr;

   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign can_load  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (reg_type'(paddr[3:2]))
         REG_PPS:   prdata = DATA_W'(pps_ff);
         REG_SWING: prdata = DATA_W'(swing_ff);
         REG_LOOP:  prdata = DATA_W'(loop_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pps_ff   <= PPS_W'(6);
         swing_ff <= '0;
         loop_ff  <= LOOP_W'(16);
      end else if (csr_wr) begin
         case (reg_type'(paddr[3:2]))
            REG_PPS:   pps_ff   <= pwdata[PPS_W-1:0];
            REG_SWING: swing_ff <= pwdata[PPS_W-1:0];
            REG_LOOP:  loop_ff  <= pwdata[LOOP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      epps = (pps_ff == '0) ? PPS_W'(1) : pps_ff;
      if (loop_ff == '0) begin
         eloop = LOOP_W'(1);
      end else if (loop_ff > LOOP_W'(MAX_STEPS)) begin
         eloop = LOOP_W'(MAX_STEPS);
      end else begin
         eloop = loop_ff;
      end
      period_full = eloop * epps;
   end

   always_ff @(posedge clock) begin
      period_ff <= period_full[REM_W-1:0];
   end

   ssc_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .done      (div_done),
      .remainder (div_rem)
   );

   ssc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOT_TOTAL)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (rd_ptr_ff[SLOT_BITS-1:0]),
      .rdata (ram_rdata)
   );

   assign rd_rem     = ram_rdata[SLOT_W-1 -: DUR_W];
   assign rd_note    = ram_rdata[NOTE_W-1:0];
   assign slot_hit   = proc_valid_ff & busy_ff[proc_idx_ff];
   assign slot_stall = slot_hit & (rd_rem == DUR_W'(1)) & ~can_load;

   always_comb begin
      fire      = ~nt_ff[NT_W-1] & (nt_ff[PC_W-1:0] == pc_ff);
      next_inc  = {1'b0, step_rem_ff} + LOOP_W'(1);
      next_idx  = (next_inc == eloop) ? '0 : next_inc;
      trig_prod = next_idx[STEP_W-1:0] * epps;
      trig_new  = NT_W'({1'b0, trig_prod});
      if (next_idx[0]) begin
         trig_new = trig_new + {{(NT_W-PPS_W){swing_ff[PPS_W-1]}}, swing_ff};
      end
   end

   always_comb begin
      track_ok   = int'(cmd_ff.track_index) < TRACK_COUNT;
      track_busy = busy_ff[int'(cmd_ff.track_index) * SLOTS_PER_TRACK +: SLOTS_PER_TRACK];
      free_found = 1'b0;
      free_addr  = '0;
      for (int i = SLOTS_PER_TRACK - 1; i >= 0; i--) begin
         if (!track_busy[i]) begin
            free_found = 1'b1;
            free_addr  = SLOT_BITS'(int'(cmd_ff.track_index) * SLOTS_PER_TRACK + i);
         end
      end
      free_found = free_found & track_ok;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      play_in       = play_ff;
      pc_in         = pc_ff;
      step_in       = step_ff;
      nt_in         = nt_ff;
      busy_in       = busy_ff;
      rd_ptr_in     = rd_ptr_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      phase_in      = phase_ff;
      step_rem_in   = step_rem_ff;
      div_req       = '0;
      ram_we        = 1'b0;
      ram_waddr     = proc_idx_ff;
      ram_wdata     = {rd_rem - DUR_W'(1), rd_note};
      ram_re        = 1'b0;
      rsp_load      = 1'b0;
      rsp_next      = '0;
      rsp_next.step_number = step_ff;
      rsp_next.running     = play_ff;

      if (state_ff != ST_IDLE && !phase_ff && div_done) begin
         step_rem_in      = div_rem[STEP_W-1:0];
         phase_in         = 1'b1;
         div_req.start    = 1'b1;
         div_req.dividend = DIV_W'(pc_ff) + DIV_W'(1);
         div_req.divisor  = period_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in = req_data;
               if (cmd_type'(req_data.command) == CMD_PULSE && play_ff) begin
                  state_in         = ST_SCAN;
                  rd_ptr_in        = '0;
                  proc_valid_in    = 1'b0;
                  phase_in         = 1'b0;
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(step_ff) + DIV_W'(1);
                  div_req.divisor  = REM_W'(eloop);
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end

         ST_SCAN: begin
            if (!slot_stall) begin
               if (slot_hit) begin
                  ram_we = 1'b1;
                  if (rd_rem == DUR_W'(1)) begin
                     busy_in[proc_idx_ff] = 1'b0;
                     rsp_load             = 1'b1;
                     rsp_next.kind        = KIND_NOTE_OFF;
                     rsp_next.out_track   = 2'(proc_idx_ff / SLOTS_PER_TRACK);
                     rsp_next.out_note    = rd_note;
                  end
               end
               if (rd_ptr_ff < (SLOT_BITS+1)'(SLOT_TOTAL)) begin
                  ram_re        = 1'b1;
                  proc_valid_in = 1'b1;
                  proc_idx_in   = rd_ptr_ff[SLOT_BITS-1:0];
                  rd_ptr_in     = rd_ptr_ff + (SLOT_BITS+1)'(1);
               end else begin
                  proc_valid_in = 1'b0;
                  if (!proc_valid_ff) begin
                     state_in = ST_FINAL;
                  end
               end
            end
         end

         ST_FINAL: begin
            if (can_load && (cmd_type'(cmd_ff.command) != CMD_PULSE || !play_ff
                             || (div_done && phase_ff))) begin
               rsp_load      = 1'b1;
               rsp_next.last = 1'b1;
               state_in      = ST_IDLE;
               case (cmd_type'(cmd_ff.command))
                  CMD_PULSE: begin
                     if (play_ff) begin
                        pc_in = div_rem;
                        if (fire) begin
                           step_in              = step_rem_ff;
                           nt_in                = trig_new;
                           rsp_next.kind        = KIND_STEP;
                           rsp_next.step_number = step_rem_ff;
                        end
                     end
                  end
                  CMD_TOGGLE: begin
                     if (play_ff) begin
                        play_in = 1'b0;
                     end else begin
                        play_in              = 1'b1;
                        pc_in                = '0;
                        nt_in                = '0;
                        step_in              = STEP_W'(eloop - LOOP_W'(1));
                        rsp_next.step_number = STEP_W'(eloop - LOOP_W'(1));
                     end
                     rsp_next.running = ~play_ff;
                  end
                  CMD_ADD: begin
                     rsp_next.out_track = cmd_ff.track_index;
                     if (free_found) begin
                        ram_we             = 1'b1;
                        ram_waddr          = free_addr;
                        ram_wdata          = {cmd_ff.note_duration, cmd_ff.note_number};
                        busy_in[free_addr] = 1'b1;
                        rsp_next.kind      = KIND_NOTE_OK;
                        rsp_next.out_note  = cmd_ff.note_number;
                     end else begin
                        rsp_next.kind = KIND_FULL;
                     end
                  end
                  default: ;
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      proc_idx_ff <= proc_idx_in;
      step_rem_ff <= step_rem_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         play_ff       <= 1'b0;
         pc_ff         <= '0;
         step_ff       <= '0;
         nt_ff         <= '0;
         busy_ff       <= '0;
         rd_ptr_ff     <= '0;
         proc_valid_ff <= 1'b0;
         phase_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         play_ff       <= play_in;
         pc_ff         <= pc_in;
         step_ff       <= step_in;
         nt_ff         <= nt_in;
         busy_ff       <= busy_in;
         rd_ptr_ff     <= rd_ptr_in;
         proc_valid_ff <= proc_valid_in;
         phase_ff      <= phase_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_note_off_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_type'(rsp_data_ff.kind) == KIND_NOTE_OFF
         |-> !rsp_data_ff.last && rsp_data_ff.running)
      else $error("note-off transfer marked last or sent while stopped");

   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> state_ff == ST_SCAN || state_ff == ST_FINAL)
      else $error("slot walk left to an unexpected state");

   a_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re |-> ram_waddr != rd_ptr_ff[SLOT_BITS-1:0])
      else $error("slot write and read hit the same entry");

   a_final_has_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL && rsp_load && play_ff
         && cmd_type'(cmd_ff.command) == CMD_PULSE |-> div_done && phase_ff)
      else $error("pulse finished before the wrap values were ready");

endmodule

`default_nettype wire

### rtl/ssc_ram.sv
`default_nettype none

module ssc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/ssc_rem.sv
`default_nettype none

module ssc_rem (
   input  logic                      clock,
   input  logic                      reset,
   input  ssc_pkg::div_req_type      div_req,
   output logic                      done,
   output logic [ssc_pkg::REM_W-1:0] remainder
);

   import ssc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, num_ff[DIV_W-1]};
      if (div_req.start) begin
         num_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = REM_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[REM_W-1:0];
         end
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
